FILE: hw/rtl/variable_length_bit_packer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit packer
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_BIT_PACKER_TOP_MACROS_SVH
`define VARIABLE_LENGTH_BIT_PACKER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Assertion that is ignored while reset is active
`define VLBP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bit packer assertion failed");
// Assertion that is checked during reset as well
`define VLBP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bit packer assertion failed");
`else
`define VLBP_ASSERT(name, clk, rstn, prop)
`define VLBP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: hw/rtl/vlbp_pkg.sv
// ----------------------------------------------------------------------------
// Bit packer package
// Widths, command codes, controller states and shared control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package vlbp_pkg;

  // Field widths
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FILL_W         = 3;
  localparam int unsigned CAP_W          = 32;
  localparam int unsigned IDX_W          = $clog2(MAX_FIELD_BITS);

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_MSB     = 2'd0,
    CMD_LSB     = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  // Requests to the capacity counter
  typedef struct packed {
    logic restart;
    logic consume;
  } cap_ctrl_t;

  // Capacity counter status
  typedef struct packed {
    logic empty;
    logic last_unit;
  } cap_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vlbp_if.sv
// ----------------------------------------------------------------------------
// Bit packer channels
// Valid/ready channels for command items and packed byte items.
// ----------------------------------------------------------------------------
`default_nettype none

// Command item channel
interface vlbp_in_if;
  logic                              valid;
  logic                              ready;
  logic [vlbp_pkg::CMD_W-1:0]        command;
  logic [vlbp_pkg::VALUE_W-1:0]      value;
  logic [vlbp_pkg::COUNT_W-1:0]      bit_count;

  modport source (output valid, command, value, bit_count, input ready);
  modport sink   (input valid, command, value, bit_count, output ready);
endinterface

// Packed byte item channel
interface vlbp_out_if;
  logic                              valid;
  logic                              ready;
  logic [vlbp_pkg::BYTE_W-1:0]       out_byte;
  logic                              space_exhausted;
  logic                              dropped;
  logic                              last;

  modport source (output valid, out_byte, space_exhausted, dropped, last, input ready);
  modport sink   (input valid, out_byte, space_exhausted, dropped, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vlbp_capacity.sv
// ----------------------------------------------------------------------------
// Bit packer capacity counter
// Holds the capacity register and counts down the bytes still allowed.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbp_capacity (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [vlbp_pkg::CAP_W-1:0] cfg_data_i,
  input  wire vlbp_pkg::cap_ctrl_t        ctrl_i,
  output      vlbp_pkg::cap_stat_t        stat_o
);
  import vlbp_pkg::*;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CAP_W-1:0] left_q, left_d;

  // Config write beats restart, restart beats a consumed byte
  always_comb begin
    cap_d  = cap_q;
    left_d = left_q;
    if (cfg_we_i) begin
      cap_d  = cfg_data_i;
      left_d = cfg_data_i;
    end else if (ctrl_i.restart) begin
      left_d = cap_q;
    end else if (ctrl_i.consume && (left_q != '0)) begin
      left_d = left_q - CAP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '1;
      left_q <= '1;
    end else begin
      cap_q  <= cap_d;
      left_q <= left_d;
    end
  end

  // Status for the byte being emitted this cycle
  assign stat_o.empty     = (left_q == '0);
  assign stat_o.last_unit = (left_q == CAP_W'(1));

endmodule

`default_nettype wire

FILE: hw/rtl/variable_length_bit_packer_top.sv
// ----------------------------------------------------------------------------
// Variable-length bit packer
// Packs 0 to 64 bit fields MSB-first or LSB-first into a byte stream.
// ----------------------------------------------------------------------------
// One command item is taken at a time. An append moves one bit per cycle
// into the byte shifter; a count above 64 counts as 64. Each completed
// byte goes to the output register in the cycle its eighth bit enters. The
// bit loop stalls while the output register holds a byte nobody has taken.
// Capacity writes reload the byte budget and may only be made while idle.
`default_nettype none
`include "variable_length_bit_packer_top_macros.svh"

module variable_length_bit_packer_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  vlbp_in_if.sink                         in_i,
  vlbp_out_if.source                      out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [vlbp_pkg::CAP_W-1:0] cfg_data_i
);
  import vlbp_pkg::*;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [BYTE_W-2:0]  part_q, part_d;

  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic               exh_q, exh_d;
  logic               drop_q, drop_d;
  logic               last_q, last_d;

  logic               in_fire;
  logic               out_free;
  logic [COUNT_W-1:0] rem_m1;
  logic [COUNT_W-1:0] count_clamped;
  logic               new_bit;
  logic [BYTE_W-1:0]  acc;
  logic [BYTE_W-1:0]  pad_byte;
  logic               emit;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_last;
  cap_ctrl_t          cap_ctrl;
  cap_stat_t          cap_stat;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // Oversized counts are cut to the maximum field width
  assign count_clamped = (in_i.bit_count > COUNT_W'(MAX_FIELD_BITS)) ?
                         COUNT_W'(MAX_FIELD_BITS) : in_i.bit_count;

  // Next bit: indexed from the top for MSB-first, shifted out at bit 0 else
  assign rem_m1  = rem_q - COUNT_W'(1);
  assign new_bit = (cmd_q == CMD_MSB) ? val_q[rem_m1[IDX_W-1:0]] : val_q[0];
  assign acc     = {part_q, new_bit};

  // Close: left-justify the pending bits, zero padded
  assign pad_byte = {1'b0, part_q} << (4'(BYTE_W) - {1'b0, fill_q});

  // Bit loop controller
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    rem_d     = rem_q;
    fill_d    = fill_q;
    part_d    = part_q;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    cap_ctrl  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d   = cmd_e'(in_i.command);
          val_d   = in_i.value;
          rem_d   = count_clamped;
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        case (cmd_q)
          CMD_MSB, CMD_LSB: begin
            if (rem_q == '0) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              rem_d = rem_m1;
              if (cmd_q == CMD_LSB) begin
                val_d = val_q >> 1;
              end
              if (fill_q == FILL_W'(BYTE_W - 1)) begin
                // eighth bit: byte complete, last if no full byte remains
                emit      = 1'b1;
                emit_byte = acc;
                emit_last = (rem_m1 < COUNT_W'(BYTE_W));
                part_d    = '0;
                fill_d    = '0;
              end else begin
                part_d = acc[BYTE_W-2:0];
                fill_d = fill_q + FILL_W'(1);
              end
              if (rem_m1 == '0) begin
                state_d = ST_IDLE;
              end
            end
          end
          CMD_CLOSE: begin
            if (fill_q == '0) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              emit      = 1'b1;
              emit_byte = pad_byte;
              emit_last = 1'b1;
              part_d    = '0;
              fill_d    = '0;
              state_d   = ST_IDLE;
            end
          end
          CMD_RESTART: begin
            part_d           = '0;
            fill_d           = '0;
            cap_ctrl.restart = 1'b1;
            state_d          = ST_IDLE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cap_ctrl.consume = emit;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    exh_d       = exh_q;
    drop_d      = drop_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      exh_d       = cap_stat.empty || cap_stat.last_unit;
      drop_d      = cap_stat.empty;
      last_d      = emit_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      fill_q      <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    out_byte_q <= out_byte_d;
    exh_q      <= exh_d;
    drop_q     <= drop_d;
    last_q     <= last_d;
  end

  vlbp_capacity u_capacity (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (cap_ctrl),
    .stat_o     (cap_stat)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = out_byte_q;
  assign out_o.space_exhausted = exh_q;
  assign out_o.dropped         = drop_q;
  assign out_o.last            = last_q;

  // A new byte only appears while an item is being worked on
  `VLBP_ASSERT(a_emit_busy, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_BUSY))
  // An accepted item always moves the controller into the bit loop
  `VLBP_ASSERT(a_fire_busy, clk_i, rst_ni, in_fire |=> (state_q == ST_BUSY))
  // A dropped byte is always flagged as out of space
  `VLBP_ASSERT(a_drop_exh, clk_i, rst_ni, (out_valid_q && drop_q) |-> exh_q)

endmodule

`default_nettype wire
